>>> src/cwrb_pkg.sv
// Package for the convolution window ring buffer.
// Shared constants, command and status codes, and the front-to-back op record.
// No dependencies.
package cwrb_pkg;

  // Default sizes of the ring
  localparam int unsigned DefMaxRows  = 8;
  localparam int unsigned DefMaxWidth = 2048;

  // Entries in the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Field widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned WordW   = 16;
  localparam int unsigned RowIdxW = 3;
  localparam int unsigned ColIdxW = 11;
  localparam int unsigned StatW   = 2;
  localparam int unsigned HeldW   = 4;
  localparam int unsigned WinRegW = 4;
  localparam int unsigned WidRegW = 12;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 12;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  // Commands
  localparam logic [CmdW-1:0] CmdAppend = 2'd0;
  localparam logic [CmdW-1:0] CmdRead   = 2'd1;
  localparam logic [CmdW-1:0] CmdClear  = 2'd2;

  // Result status
  localparam logic [StatW-1:0] StatOk      = 2'd0;
  localparam logic [StatW-1:0] StatPartial = 2'd1;
  localparam logic [StatW-1:0] StatRange   = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegWindowRows = 1'd0;
  localparam logic [CfgIdxW-1:0] RegRowWidth   = 1'd1;

  // Register reset values
  localparam logic [WinRegW-1:0] WindowRowsRst = 4'd4;
  localparam logic [WidRegW-1:0] RowWidthRst   = 12'd2048;

  // One classified item, handed from front to back
  typedef struct packed {
    logic             mem_wr;
    logic             mem_rd;
    logic [WordW-1:0] word;
    logic [StatW-1:0] status;
    logic [HeldW-1:0] rows_held;
    logic             completed;
  } op_t;

endpackage

>>> src/cwrb_front.sv
// Front of the window ring buffer: config registers, ring pointers, item decode.
// Produces one op record and a store address per accepted beat.
// Depends on cwrb_pkg.
module cwrb_front #(
  parameter int unsigned MAX_ROWS  = cwrb_pkg::DefMaxRows,
  parameter int unsigned MAX_WIDTH = cwrb_pkg::DefMaxWidth,
  parameter int unsigned AW = (MAX_ROWS * MAX_WIDTH > 1) ? $clog2(MAX_ROWS * MAX_WIDTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cwrb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cwrb_pkg::CfgDatW-1:0] cfg_data_i,
  input  logic                         accept_i,
  input  logic [cwrb_pkg::CmdW-1:0]    cmd_i,
  input  logic [cwrb_pkg::WordW-1:0]   word_i,
  input  logic [cwrb_pkg::RowIdxW-1:0] row_i,
  input  logic [cwrb_pkg::ColIdxW-1:0] col_i,
  output cwrb_pkg::op_t                op_o,
  output logic [AW-1:0]                addr_o
);

  localparam int unsigned HW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned HDW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned FW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [cwrb_pkg::WinRegW-1:0] win_q;
  logic [cwrb_pkg::WidRegW-1:0] wid_q;
  logic [HDW-1:0] head_q, head_d;
  logic [HW-1:0]  held_q, held_d;
  logic [CLW-1:0] fill_q, fill_d;

  logic [HW-1:0]  ws;
  logic [FW-1:0]  wd;
  logic [FW-1:0]  fill_inc;
  logic [HW-1:0]  head_inc;
  logic [HW:0]    slot_sum;
  logic [HDW-1:0] slot;
  logic           in_range;
  logic           real_row;

  // Effective window size and row width, with out-of-range values clamped
  always_comb begin
    if (win_q == '0) begin
      ws = HW'(1);
    end else if (32'(win_q) > MAX_ROWS) begin
      ws = HW'(MAX_ROWS);
    end else begin
      ws = HW'(win_q);
    end
    if (wid_q == '0) begin
      wd = FW'(1);
    end else if (32'(wid_q) > MAX_WIDTH) begin
      wd = FW'(MAX_WIDTH);
    end else begin
      wd = FW'(wid_q);
    end
  end

  assign fill_inc = FW'(fill_q) + FW'(1);
  assign head_inc = HW'(head_q) + HW'(1);
  assign in_range = (32'(row_i) < 32'(ws)) && (32'(col_i) < 32'(wd));
  assign real_row = (32'(row_i) + 32'(held_q)) >= 32'(ws);
  assign slot_sum = (HW + 1)'(head_q) + (HW + 1)'(row_i);
  assign slot     = (slot_sum >= (HW + 1)'(ws)) ? HDW'(slot_sum - (HW + 1)'(ws))
                                                 : HDW'(slot_sum);

  always_comb begin
    head_d = head_q;
    held_d = held_q;
    fill_d = fill_q;
    op_o   = '0;
    addr_o = AW'(head_q) * AW'(MAX_WIDTH) + AW'(fill_q);
    case (cmd_i)
      cwrb_pkg::CmdAppend: begin
        op_o.mem_wr = 1'b1;
        op_o.word   = word_i;
        if (fill_inc >= wd) begin
          fill_d         = '0;
          head_d         = (head_inc >= ws) ? '0 : HDW'(head_inc);
          held_d         = (held_q < ws) ? held_q + HW'(1) : held_q;
          op_o.completed = 1'b1;
        end else begin
          fill_d = CLW'(fill_inc);
        end
      end
      cwrb_pkg::CmdRead: begin
        addr_o = AW'(slot) * AW'(MAX_WIDTH) + AW'(col_i);
        if (!in_range) begin
          op_o.status = cwrb_pkg::StatRange;
        end else if (fill_q != '0) begin
          op_o.status = cwrb_pkg::StatPartial;
        end else begin
          op_o.status = cwrb_pkg::StatOk;
          op_o.mem_rd = real_row;
        end
      end
      cwrb_pkg::CmdClear: begin
        head_d = '0;
        held_d = '0;
        fill_d = '0;
      end
      default: begin
      end
    endcase
    op_o.rows_held = cwrb_pkg::HeldW'(held_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= cwrb_pkg::WindowRowsRst;
      wid_q  <= cwrb_pkg::RowWidthRst;
      head_q <= '0;
      held_q <= '0;
      fill_q <= '0;
    end else if (cfg_we_i) begin
      // any register write empties the window
      head_q <= '0;
      held_q <= '0;
      fill_q <= '0;
      case (cfg_idx_i)
        cwrb_pkg::RegWindowRows: win_q <= cfg_data_i[cwrb_pkg::WinRegW-1:0];
        cwrb_pkg::RegRowWidth:   wid_q <= cfg_data_i;
        default: begin
        end
      endcase
    end else if (accept_i) begin
      head_q <= head_d;
      held_q <= held_d;
      fill_q <= fill_d;
    end
  end

endmodule

>>> src/cwrb_queue.sv
// Small FIFO between front and back of the window ring buffer.
// Flop based, one push and one pop per cycle. Depends on cwrb_pkg.
module cwrb_queue #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = cwrb_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] slot_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

>>> src/cwrb_back.sv
// Back of the window ring buffer: the word store and the output register.
// Takes op records from the queue in order. Depends on cwrb_pkg.
module cwrb_back #(
  parameter int unsigned MAX_ROWS  = cwrb_pkg::DefMaxRows,
  parameter int unsigned MAX_WIDTH = cwrb_pkg::DefMaxWidth,
  parameter int unsigned AW = (MAX_ROWS * MAX_WIDTH > 1) ? $clog2(MAX_ROWS * MAX_WIDTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  cwrb_pkg::op_t                 op_i,
  input  logic [AW-1:0]                 addr_i,
  output logic                          pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [cwrb_pkg::WordW-1:0]    word_o,
  output logic [cwrb_pkg::StatW-1:0]    status_o,
  output logic [cwrb_pkg::HeldW-1:0]    rows_held_o,
  output logic                          completed_o
);

  localparam int unsigned Depth = MAX_ROWS * MAX_WIDTH;

  logic [cwrb_pkg::WordW-1:0] mem [Depth];
  logic [cwrb_pkg::WordW-1:0] rdata_q;
  cwrb_pkg::op_t              meta_q;
  logic                       valid_q;

  assign pop_o = !q_empty_i && (!valid_q || m_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      meta_q <= op_i;
      if (op_i.mem_wr) begin
        mem[addr_i] <= op_i.word;
      end
      if (op_i.mem_rd) begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign m_valid_o   = valid_q;
  assign word_o      = meta_q.mem_rd ? rdata_q : '0;
  assign status_o    = meta_q.status;
  assign rows_held_o = meta_q.rows_held;
  assign completed_o = meta_q.completed;

endmodule

>>> src/conv_window_ring_buffer.sv
// Sliding window of the most recent rows of fp16 words, kept in a ring of row slots.
// Top level: front (decode, ring pointers), queue, back (word store, output).
// Depends on cwrb_pkg, cwrb_front, cwrb_queue, cwrb_back.
//
// Each input beat is one command: append a word as the next column of the row
// being filled, read one word of the window (row 0 is the oldest), or clear the
// window; every beat gives exactly one result beat. The block takes one beat per
// clock and returns one per clock when both sides keep up; each beat waits in
// the front-to-back queue, and its result, with the single-port store read, is
// registered in the output register of the back end. The store holds
// MAX_ROWS x MAX_WIDTH words, has no reset and needs no clearing pass: only
// complete rows are ever read. A row counts once its last column is written.
// Reads of padding rows give zero with status ok; a bad index gives status 2,
// a read while a row is half written status 1, both with a zero word.
// window_rows of zero acts as one and values above MAX_ROWS as MAX_ROWS; the
// same holds for row_width against MAX_WIDTH. Any register write empties the
// window and should be made only while the block is idle.
module conv_window_ring_buffer #(
  parameter int unsigned MAX_ROWS  = cwrb_pkg::DefMaxRows,
  parameter int unsigned MAX_WIDTH = cwrb_pkg::DefMaxWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [cwrb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cwrb_pkg::CfgDatW-1:0]   cfg_data_i,
  // command stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] word_in, [18:16] row_index, [29:19] column_index, [31:30] zero
  input  logic [cwrb_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] cmd
  input  logic [cwrb_pkg::CmdW-1:0]      s_axis_tuser,
  // result stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] word_out, [17:16] status, [21:18] rows_held, [22] row_completed, [23] zero
  output logic [cwrb_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned AW = (MAX_ROWS * MAX_WIDTH > 1) ? $clog2(MAX_ROWS * MAX_WIDTH) : 1;
  localparam int unsigned QW = $bits(cwrb_pkg::op_t) + AW;

  cwrb_pkg::op_t front_op, back_op;
  logic [AW-1:0] front_addr, back_addr;
  logic [QW-1:0] q_out;
  logic          q_full, q_empty, push, pop;

  logic [cwrb_pkg::WordW-1:0] word_out;
  logic [cwrb_pkg::StatW-1:0] status;
  logic [cwrb_pkg::HeldW-1:0] rows_held;
  logic                       completed;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  cwrb_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (push),
    .cmd_i      (s_axis_tuser),
    .word_i     (s_axis_tdata[15:0]),
    .row_i      (s_axis_tdata[18:16]),
    .col_i      (s_axis_tdata[29:19]),
    .op_o       (front_op),
    .addr_o     (front_addr)
  );

  cwrb_queue #(
    .DW    (QW),
    .DEPTH (cwrb_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({front_addr, front_op}),
    .pop_i   (pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign back_op   = q_out[$bits(cwrb_pkg::op_t)-1:0];
  assign back_addr = q_out[QW-1:$bits(cwrb_pkg::op_t)];

  cwrb_back #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .op_i        (back_op),
    .addr_i      (back_addr),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .word_o      (word_out),
    .status_o    (status),
    .rows_held_o (rows_held),
    .completed_o (completed)
  );

  assign m_axis_tdata = {1'b0, completed, rows_held, status, word_out};

endmodule
